### src/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/rtpj_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rtpj_pkg;

	// sizing of the downstream packet buffer, bounds the declared length
	localparam int PACKET_BUFFER_BYTES = 2048;
	localparam int MAX_PAYLOAD_LEN     = PACKET_BUFFER_BYTES - 24;
	localparam int LEN_W               = 11;
	localparam int HDR_IDX_W           = 5;

	// header lengths with and without the interleaved prefix
	localparam logic [HDR_IDX_W-1:0] HDR_LEN_PLAIN = 5'd20;
	localparam logic [HDR_IDX_W-1:0] HDR_LEN_ILV   = 5'd24;
	localparam logic [HDR_IDX_W-1:0] PREFIX_LEN    = 5'd4;
	localparam logic [16:0]          ILV_LEN_ADD   = 17'd20;

	// register indexes
	localparam logic [2:0] REG_INTERLEAVED = 3'd0;
	localparam logic [2:0] REG_TS_STEP     = 3'd1;
	localparam logic [2:0] REG_SSRC        = 3'd2;
	localparam logic [2:0] REG_QUALITY     = 3'd3;
	localparam logic [2:0] REG_C0_WIDTH    = 3'd4;
	localparam logic [2:0] REG_C0_HEIGHT   = 3'd5;
	localparam logic [2:0] REG_C1_WIDTH    = 3'd6;
	localparam logic [2:0] REG_C1_HEIGHT   = 3'd7;

	// register reset values
	localparam logic [31:0] RST_TS_STEP   = 32'd3600;
	localparam logic [31:0] RST_SSRC      = 32'h13f9_7e67;
	localparam logic [7:0]  RST_QUALITY   = 8'h5e;
	localparam logic [7:0]  RST_C0_WIDTH  = 8'h06;
	localparam logic [7:0]  RST_C0_HEIGHT = 8'h04;
	localparam logic [7:0]  RST_C1_WIDTH  = 8'h08;
	localparam logic [7:0]  RST_C1_HEIGHT = 8'h06;

	// fixed header bytes
	localparam logic [7:0] ILV_MAGIC   = 8'h24;
	localparam logic [7:0] ILV_CHANNEL = 8'h00;
	localparam logic [7:0] RTP_VER     = 8'h80;
	localparam logic [7:0] RTP_MK_PT   = 8'h9a;
	localparam logic [7:0] JPEG_ZERO   = 8'h00;
	localparam logic [7:0] JPEG_TYPE   = 8'h01;

	typedef struct packed {
		logic [7:0]       data;
		logic             sop;
		logic             eop;
		logic [LEN_W-1:0] len;
		logic             chn;
	} item_t;

endpackage
`default_nettype wire

### src/rtp_jpeg_packetizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted byte is held in the input stage, then loaded into the output register; a
// packet-start byte first sends 20 header bytes (24 interleaved), one per unstalled cycle
// throughput: one output byte per cycle unless stalled, set by the single output register
// input stalls at each packet start while the header goes out
// reset: asynchronous, clears the counters, restores register defaults, empties stages
`include "assert_macros.svh"

module rtp_jpeg_packetizer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// input byte stream
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  payload_byte,
	input  wire logic        start_of_packet,
	input  wire logic        end_of_packet,
	input  wire logic [rtpj_pkg::LEN_W-1:0] payload_length,
	input  wire logic        channel_select,
	// framed output stream
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             packet_end
);

	// configuration registers
	logic        interleaved_q;
	logic [31:0] ts_step_q;
	logic [31:0] ssrc_q;
	logic [7:0]  quality_q;
	logic [7:0]  c0_width_q;
	logic [7:0]  c0_height_q;
	logic [7:0]  c1_width_q;
	logic [7:0]  c1_height_q;

	// packet counters
	logic [15:0] seq_q;
	logic [31:0] ts_q;

	// input stage: held item and header byte counter
	rtpj_pkg::item_t item_s1;
	logic            valid_s1;
	logic [rtpj_pkg::HDR_IDX_W-1:0] hdr_idx_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_end_q;

	logic                           out_load;
	logic                           emit;
	logic                           hdr_pending;
	logic                           item_done;
	logic                           in_accept;
	logic [rtpj_pkg::HDR_IDX_W-1:0] hdr_len;
	logic [rtpj_pkg::HDR_IDX_W-1:0] hdr_pos;
	logic [rtpj_pkg::LEN_W-1:0]     len_sat;
	logic [16:0]                    total_len;
	logic [7:0]                     hdr_byte;
	logic [7:0]                     width_sel;
	logic [7:0]                     height_sel;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interleaved_q <= 1'b0;
			ts_step_q     <= rtpj_pkg::RST_TS_STEP;
			ssrc_q        <= rtpj_pkg::RST_SSRC;
			quality_q     <= rtpj_pkg::RST_QUALITY;
			c0_width_q    <= rtpj_pkg::RST_C0_WIDTH;
			c0_height_q   <= rtpj_pkg::RST_C0_HEIGHT;
			c1_width_q    <= rtpj_pkg::RST_C1_WIDTH;
			c1_height_q   <= rtpj_pkg::RST_C1_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtpj_pkg::REG_INTERLEAVED: interleaved_q <= cfg_data[0];
				rtpj_pkg::REG_TS_STEP:     ts_step_q     <= cfg_data;
				rtpj_pkg::REG_SSRC:        ssrc_q        <= cfg_data;
				rtpj_pkg::REG_QUALITY:     quality_q     <= cfg_data[7:0];
				rtpj_pkg::REG_C0_WIDTH:    c0_width_q    <= cfg_data[7:0];
				rtpj_pkg::REG_C0_HEIGHT:   c0_height_q   <= cfg_data[7:0];
				rtpj_pkg::REG_C1_WIDTH:    c1_width_q    <= cfg_data[7:0];
				rtpj_pkg::REG_C1_HEIGHT:   c1_height_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// handshake: the output register loads when empty or being drained
	assign hdr_len     = interleaved_q ? rtpj_pkg::HDR_LEN_ILV : rtpj_pkg::HDR_LEN_PLAIN;
	assign hdr_pending = valid_s1 && item_s1.sop && (hdr_idx_q < hdr_len);
	assign out_load    = !out_valid_q || !out_stall;
	assign emit        = valid_s1 && out_load;
	assign item_done   = emit && !hdr_pending;
	assign in_stall    = valid_s1 && !item_done;
	assign in_accept   = in_valid && !in_stall;

	// header byte selection; plain packets skip the four prefix positions
	assign hdr_pos    = interleaved_q ? hdr_idx_q : hdr_idx_q + rtpj_pkg::PREFIX_LEN;
	assign len_sat    = (17'(item_s1.len) > 17'(rtpj_pkg::MAX_PAYLOAD_LEN))
		? rtpj_pkg::LEN_W'(rtpj_pkg::MAX_PAYLOAD_LEN) : item_s1.len;
	assign total_len  = 17'(len_sat) + rtpj_pkg::ILV_LEN_ADD;
	assign width_sel  = item_s1.chn ? c1_width_q : c0_width_q;
	assign height_sel = item_s1.chn ? c1_height_q : c0_height_q;

	always_comb begin
		case (hdr_pos)
			// interleaved prefix
			5'd0:  hdr_byte = rtpj_pkg::ILV_MAGIC;
			5'd1:  hdr_byte = rtpj_pkg::ILV_CHANNEL;
			5'd2:  hdr_byte = total_len[15:8];
			5'd3:  hdr_byte = total_len[7:0];
			// rtp header
			5'd4:  hdr_byte = rtpj_pkg::RTP_VER;
			5'd5:  hdr_byte = rtpj_pkg::RTP_MK_PT;
			5'd6:  hdr_byte = seq_q[15:8];
			5'd7:  hdr_byte = seq_q[7:0];
			5'd8:  hdr_byte = ts_q[31:24];
			5'd9:  hdr_byte = ts_q[23:16];
			5'd10: hdr_byte = ts_q[15:8];
			5'd11: hdr_byte = ts_q[7:0];
			5'd12: hdr_byte = ssrc_q[31:24];
			5'd13: hdr_byte = ssrc_q[23:16];
			5'd14: hdr_byte = ssrc_q[15:8];
			5'd15: hdr_byte = ssrc_q[7:0];
			// jpeg header: zero type-specific and fragment offset, then type, quality, width and height
			5'd16: hdr_byte = rtpj_pkg::JPEG_ZERO;
			5'd17: hdr_byte = rtpj_pkg::JPEG_ZERO;
			5'd18: hdr_byte = rtpj_pkg::JPEG_ZERO;
			5'd19: hdr_byte = rtpj_pkg::JPEG_ZERO;
			5'd20: hdr_byte = rtpj_pkg::JPEG_TYPE;
			5'd21: hdr_byte = quality_q;
			5'd22: hdr_byte = width_sel;
			5'd23: hdr_byte = height_sel;
			default: hdr_byte = rtpj_pkg::JPEG_ZERO;
		endcase
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			hdr_idx_q <= '0;
		end else begin
			if (in_accept) begin
				valid_s1  <= 1'b1;
				hdr_idx_q <= '0;
			end else begin
				if (item_done) valid_s1 <= 1'b0;
				if (emit && hdr_pending) hdr_idx_q <= hdr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.data <= payload_byte;
			item_s1.sop  <= start_of_packet;
			item_s1.eop  <= end_of_packet;
			item_s1.len  <= payload_length;
			item_s1.chn  <= channel_select;
		end
	end

	// counters advance as the last payload byte of a packet goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
			ts_q  <= '0;
		end else if (item_done && item_s1.eop) begin
			seq_q <= seq_q + 16'd1;
			ts_q  <= ts_q + ts_step_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= hdr_pending ? hdr_byte : item_s1.data;
			out_end_q  <= !hdr_pending && item_s1.eop;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign packet_end = out_end_q;

	`ASSERT_CLK(a_stall_in_header, !hdr_pending || in_stall, "input taken while header pending")
	`ASSERT_CLK(a_hdr_idx_range, hdr_idx_q <= rtpj_pkg::HDR_LEN_ILV, "header index out of range")
	`ASSERT_NEXT(a_seq_step, item_done && item_s1.eop, seq_q == 16'($past(seq_q) + 16'd1), "sequence did not advance")
	`ASSERT_NEXT(a_hdr_no_end, emit && hdr_pending, out_valid_q && !out_end_q, "header byte flagged as packet end")

endmodule
`default_nettype wire
